// ===== hw/rtl/eed_pkg.sv =====
// ---------------------------------------------------------------------------
// eed_pkg
// Shared types, constants and byte-builder functions for the echo escape
// decoder.
// ---------------------------------------------------------------------------
package eed_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int RUN_MAX     = 7;

   localparam logic [7:0]  CH_BSLASH  = 8'h5C;
   localparam logic [7:0]  ESC_CODE   = 8'h1B;
   localparam logic [31:0] UTF8_LIMIT = 32'h7FFF_FFFF;
   localparam logic [31:0] CP_1BYTE   = 32'h0000_007F;
   localparam logic [31:0] CP_2BYTE   = 32'h0000_07FF;
   localparam logic [31:0] CP_3BYTE   = 32'h0000_FFFF;
   localparam logic [31:0] CP_4BYTE   = 32'h001F_FFFF;
   localparam logic [31:0] CP_5BYTE   = 32'h03FF_FFFF;
   localparam logic [7:0]  LEAD_2     = 8'hC0;
   localparam logic [7:0]  LEAD_3     = 8'hE0;
   localparam logic [7:0]  LEAD_4     = 8'hF0;
   localparam logic [7:0]  LEAD_5     = 8'hF8;
   localparam logic [7:0]  LEAD_6     = 8'hFC;
   localparam logic [7:0]  CONT_MARK  = 8'h80;
   localparam logic [3:0]  OCT_DIGITS = 4'd4;
   localparam logic [3:0]  HEX_DIGITS = 4'd2;
   localparam logic [3:0]  UNI_SHORT  = 4'd4;
   localparam logic [3:0]  UNI_LONG   = 4'd8;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_BSLASH,
      PH_OCT,
      PH_HEX,
      PH_UNI
   } phase_type;

   // all result bytes caused by one input transfer
   typedef struct packed {
      logic [RUN_MAX-1:0][7:0] bytes;
      logic [2:0]              count;
      logic                    stopped;
   } run_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic run_type put_byte(run_type r, logic [7:0] b);
      run_type t;
      t = r;
      if (t.count < 3'(RUN_MAX)) begin
         t.bytes[t.count] = b;
         t.count          = 3'(t.count + 3'd1);
      end
      return t;
   endfunction

   function automatic logic is_hex(logic [7:0] b);
      return b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
   endfunction

   function automatic logic [3:0] hex_val(logic [7:0] b);
      logic [7:0] v;
      if (b inside {[8'h30:8'h39]}) begin
         v = 8'(b - 8'h30);
      end else if (b inside {[8'h61:8'h66]}) begin
         v = 8'(b - 8'h57);
      end else begin
         v = 8'(b - 8'h37);
      end
      return v[3:0];
   endfunction

   function automatic run_type put_utf8(run_type r, logic [31:0] cp);
      run_type    t;
      logic [2:0] n;
      logic [7:0] lead;
      t    = r;
      n    = 3'd2;
      lead = LEAD_2;
      if (cp <= CP_1BYTE) begin
         t = put_byte(t, cp[7:0]);
      end else if (cp <= UTF8_LIMIT) begin
         if (cp <= CP_2BYTE) begin
            n = 3'd2; lead = LEAD_2 | 8'(cp >> 6);
         end else if (cp <= CP_3BYTE) begin
            n = 3'd3; lead = LEAD_3 | 8'(cp >> 12);
         end else if (cp <= CP_4BYTE) begin
            n = 3'd4; lead = LEAD_4 | 8'(cp >> 18);
         end else if (cp <= CP_5BYTE) begin
            n = 3'd5; lead = LEAD_5 | 8'(cp >> 24);
         end else begin
            n = 3'd6; lead = LEAD_6 | 8'(cp >> 30);
         end
         t = put_byte(t, lead);
         for (int i = 4; i >= 0; i--) begin
            if (3'(i) <= 3'(n - 3'd2)) begin
               t = put_byte(t, CONT_MARK | {2'b00, 6'(cp >> (6 * i))});
            end
         end
      end
      return t;
   endfunction

   function automatic run_type flush_pending(run_type r, phase_type ph, logic [31:0] acc,
                                             logic [3:0] dig, logic lng);
      run_type t;
      t = r;
      case (ph)
         PH_BSLASH: t = put_byte(t, CH_BSLASH);
         PH_OCT:    t = put_byte(t, acc[7:0]);
         PH_HEX: begin
            if (dig == 4'd0) begin
               t = put_byte(t, CH_BSLASH);
               t = put_byte(t, "x");
            end else begin
               t = put_byte(t, acc[7:0]);
            end
         end
         PH_UNI: begin
            if (dig == 4'd0) begin
               t = put_byte(t, CH_BSLASH);
               t = put_byte(t, lng ? 8'("U") : 8'("u"));
            end else begin
               t = put_utf8(t, acc);
            end
         end
         default: ;
      endcase
      return t;
   endfunction

endpackage

// ===== hw/rtl/eed_front.sv =====
// ---------------------------------------------------------------------------
// eed_front
// Accepts text bytes, tracks the escape state and builds the run of output
// bytes for each transfer.
// ---------------------------------------------------------------------------
module eed_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  interpret_escapes,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   input  logic                  req_tuser,
   input  eed_pkg::q_status_type q_stat,
   output logic                  push,
   output eed_pkg::run_type      push_run
);

   eed_pkg::phase_type phase_ff, phase_in;
   logic [31:0]        acc_ff, acc_in;
   logic [3:0]         dig_ff, dig_in;
   logic               long_ff, long_in;
   logic               stop_ff, stop_in;
   logic               accept;

   assign req_tready = !q_stat.full;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept;

   always_comb begin
      eed_pkg::run_type r;
      logic [7:0]       b;
      logic             handled;
      logic [3:0]       limit;
      r        = '0;
      b        = req_tdata;
      handled  = 1'b0;
      limit    = eed_pkg::UNI_SHORT;
      phase_in = phase_ff;
      acc_in   = acc_ff;
      dig_in   = dig_ff;
      long_in  = long_ff;
      stop_in  = stop_ff;
      if (req_tuser) begin
         stop_in  = 1'b0;
         phase_in = eed_pkg::PH_IDLE;
         acc_in   = '0;
         dig_in   = '0;
         long_in  = 1'b0;
      end
      if (!stop_in) begin
         if (!interpret_escapes) begin
            phase_in = eed_pkg::PH_IDLE;
            acc_in   = '0;
            dig_in   = '0;
            long_in  = 1'b0;
            r        = eed_pkg::put_byte(r, b);
         end else begin
            case (phase_in)
               eed_pkg::PH_OCT: begin
                  if (b inside {[8'h30:8'h37]} && dig_in < eed_pkg::OCT_DIGITS) begin
                     acc_in  = {acc_in[28:0], b[2:0]};
                     dig_in  = 4'(dig_in + 4'd1);
                     handled = 1'b1;
                     if (dig_in >= eed_pkg::OCT_DIGITS) begin
                        r        = eed_pkg::put_byte(r, acc_in[7:0]);
                        phase_in = eed_pkg::PH_IDLE;
                        acc_in   = '0;
                        dig_in   = '0;
                        long_in  = 1'b0;
                     end
                  end else begin
                     r = eed_pkg::flush_pending(r, phase_in, acc_in, dig_in, long_in);
                     phase_in = eed_pkg::PH_IDLE;
                     acc_in   = '0;
                     dig_in   = '0;
                     long_in  = 1'b0;
                  end
               end
               eed_pkg::PH_HEX, eed_pkg::PH_UNI: begin
                  if (phase_in == eed_pkg::PH_HEX) begin
                     limit = eed_pkg::HEX_DIGITS;
                  end else if (long_in) begin
                     limit = eed_pkg::UNI_LONG;
                  end
                  if (eed_pkg::is_hex(b) && dig_in < limit) begin
                     acc_in  = {acc_in[27:0], eed_pkg::hex_val(b)};
                     dig_in  = 4'(dig_in + 4'd1);
                     handled = 1'b1;
                     if (dig_in >= limit) begin
                        if (phase_in == eed_pkg::PH_HEX) begin
                           r = eed_pkg::put_byte(r, acc_in[7:0]);
                        end else begin
                           r = eed_pkg::put_utf8(r, acc_in);
                        end
                        phase_in = eed_pkg::PH_IDLE;
                        acc_in   = '0;
                        dig_in   = '0;
                        long_in  = 1'b0;
                     end
                  end else begin
                     r = eed_pkg::flush_pending(r, phase_in, acc_in, dig_in, long_in);
                     phase_in = eed_pkg::PH_IDLE;
                     acc_in   = '0;
                     dig_in   = '0;
                     long_in  = 1'b0;
                  end
               end
               eed_pkg::PH_BSLASH: begin
                  handled  = 1'b1;
                  phase_in = eed_pkg::PH_IDLE;
                  acc_in   = '0;
                  dig_in   = '0;
                  long_in  = 1'b0;
                  case (b)
                     "a":        r = eed_pkg::put_byte(r, 8'h07);
                     "b":        r = eed_pkg::put_byte(r, 8'h08);
                     "c":        stop_in = 1'b1;
                     "e", "E":   r = eed_pkg::put_byte(r, eed_pkg::ESC_CODE);
                     "f":        r = eed_pkg::put_byte(r, 8'h0C);
                     "n":        r = eed_pkg::put_byte(r, 8'h0A);
                     "r":        r = eed_pkg::put_byte(r, 8'h0D);
                     "t":        r = eed_pkg::put_byte(r, 8'h09);
                     "v":        r = eed_pkg::put_byte(r, 8'h0B);
                     eed_pkg::CH_BSLASH: r = eed_pkg::put_byte(r, eed_pkg::CH_BSLASH);
                     "0": begin
                        phase_in = eed_pkg::PH_OCT;
                        dig_in   = 4'd1;
                     end
                     "x":        phase_in = eed_pkg::PH_HEX;
                     "u":        phase_in = eed_pkg::PH_UNI;
                     "U": begin
                        phase_in = eed_pkg::PH_UNI;
                        long_in  = 1'b1;
                     end
                     default: begin
                        r = eed_pkg::put_byte(r, eed_pkg::CH_BSLASH);
                        r = eed_pkg::put_byte(r, b);
                     end
                  endcase
               end
               default: ;
            endcase
            if (!handled) begin
               if (b == eed_pkg::CH_BSLASH) begin
                  phase_in = eed_pkg::PH_BSLASH;
               end else begin
                  r = eed_pkg::put_byte(r, b);
               end
            end
            if (req_tlast && !stop_in) begin
               r = eed_pkg::flush_pending(r, phase_in, acc_in, dig_in, long_in);
               phase_in = eed_pkg::PH_IDLE;
               acc_in   = '0;
               dig_in   = '0;
               long_in  = 1'b0;
            end
         end
      end
      r.stopped = stop_in;
      push_run  = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= eed_pkg::PH_IDLE;
         acc_ff   <= '0;
         dig_ff   <= '0;
         long_ff  <= 1'b0;
         stop_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         dig_ff   <= dig_in;
         long_ff  <= long_in;
         stop_ff  <= stop_in;
      end
   end

endmodule

// ===== hw/rtl/eed_queue.sv =====
// ---------------------------------------------------------------------------
// eed_queue
// Short queue of byte runs between the decode front and the output back.
// ---------------------------------------------------------------------------
module eed_queue #(
   parameter int DEPTH = eed_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  eed_pkg::run_type      push_run,
   input  logic                  pop,
   output eed_pkg::run_type      head,
   output eed_pkg::q_status_type q_stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   eed_pkg::run_type   mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   assign q_stat.full  = (cnt_ff == CNT_W'(DEPTH));
   assign q_stat.empty = (cnt_ff == '0);
   assign head         = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         cnt_in = CNT_W'(cnt_ff + 1'b1);
      end else if (pop && !push) begin
         cnt_in = CNT_W'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ===== hw/rtl/eed_back.sv =====
// ---------------------------------------------------------------------------
// eed_back
// Sends the queued runs out one byte per transfer and marks the last byte.
// ---------------------------------------------------------------------------
module eed_back (
   input  logic                  clock,
   input  logic                  reset,
   input  eed_pkg::run_type      head,
   input  eed_pkg::q_status_type q_stat,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tlast,
   output logic [1:0]            rsp_tuser
);

   logic [2:0] idx_ff, idx_in;
   logic       has_bytes;

   assign has_bytes  = (head.count != 3'd0);
   assign rsp_tvalid = !q_stat.empty;
   assign rsp_tdata  = head.bytes[idx_ff];
   assign rsp_tlast  = !has_bytes || (idx_ff == 3'(head.count - 3'd1));
   assign rsp_tuser  = {head.stopped, has_bytes};
   assign pop        = rsp_tvalid && rsp_tready && rsp_tlast;

   always_comb begin
      idx_in = idx_ff;
      if (rsp_tvalid && rsp_tready) begin
         idx_in = rsp_tlast ? 3'd0 : 3'(idx_ff + 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// ===== hw/rtl/echo_escape_decoder_core.sv =====
// ---------------------------------------------------------------------------
// echo_escape_decoder_core
// Shell echo backslash escape decoder: one text byte in, zero to seven
// decoded bytes out per transfer.
//
//   channel | dir | tdata         | tlast         | tuser
//   req_    | in  | in_byte       | end_of_string | message_start
//   rsp_    | out | out_byte      | last_of_run   | [0] byte_valid, [1] stopped
//   csr_    | in  | interpret_escapes write (csr_we, csr_wdata)
//
// The front decodes a byte in the cycle it is taken; a request transfer can
// be taken every cycle while the run queue (QUEUE_DEPTH runs) has room.
// The back sends one byte per cycle while rsp_tready is high, an empty run
// as one transfer with byte_valid low; sustained input rate is bounded by
// the output byte count. Each run is registered in the queue before it goes out.
// Synchronous reset clears escape state, stop mark, register and queue.
// ---------------------------------------------------------------------------
module echo_escape_decoder_core #(
   parameter int QUEUE_DEPTH = eed_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // in_byte
   input  logic       req_tlast,
   input  logic       req_tuser,    // message_start
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // out_byte
   output logic       rsp_tlast,
   output logic [1:0] rsp_tuser,    // byte_valid, stopped
   input  logic       csr_we,
   input  logic       csr_wdata
);

   logic                  interpret_ff;
   logic                  push;
   logic                  pop;
   eed_pkg::run_type      push_run;
   eed_pkg::run_type      head;
   eed_pkg::q_status_type q_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         interpret_ff <= 1'b0;
      end else if (csr_we) begin
         interpret_ff <= csr_wdata;
      end
   end

   eed_front u_front (
      .clock             (clock),
      .reset             (reset),
      .interpret_escapes (interpret_ff),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tlast         (req_tlast),
      .req_tuser         (req_tuser),
      .q_stat            (q_stat),
      .push              (push),
      .push_run          (push_run)
   );

   eed_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_run (push_run),
      .pop      (pop),
      .head     (head),
      .q_stat   (q_stat)
   );

   eed_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_stat     (q_stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   a_empty_no_valid: assert property (@(posedge clock) disable iff (reset)
      q_stat.empty |-> !rsp_tvalid)
      else $error("response valid with empty run queue");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("run ended without last byte");

   a_stopped_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tuser[1] == $past(rsp_tuser[1]))
      else $error("stopped flag changed inside a run");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast)
      else $error("empty result not marked last");

endmodule

// ===== sim/echo_escape_decoder_core_test.sv =====
// ---------------------------------------------------------------------------
// echo_escape_decoder_core_test
// Self-checking testbench for the echo escape decoder core. A behavioral
// decoder predicts the byte run of every accepted request transfer. Each
// response transfer is checked against the oldest predicted byte. The run
// covers raw copy, every escape form, message start, the stop escape and
// truncated escapes, with random stalls on both channels and a long output
// stall that fills the run queue.
// ---------------------------------------------------------------------------
module echo_escape_decoder_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD    = 120;

   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       stopped;
      logic       last;
   } result_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = '0;    // in_byte
   logic       req_tlast  = 1'b0;  // end_of_string
   logic       req_tuser  = 1'b0;  // message_start
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;          // out_byte
   logic       rsp_tlast;          // last_of_run
   logic [1:0] rsp_tuser;          // [0] byte_valid, [1] stopped
   logic       csr_we     = 1'b0;
   logic       csr_wdata  = 1'b0;

   // decoder state as seen by the prediction
   bit                 decode_on;
   eed_pkg::phase_type esc_phase  = eed_pkg::PH_IDLE;
   logic [31:0]        esc_value  = '0;
   int unsigned        esc_digits;
   bit                 esc_long;
   bit                 stop_mark;
   logic [7:0]         run_bytes[$];

   result_type  decoded_q[$];
   int unsigned error_count;
   int unsigned sent_count;
   int unsigned hold_len;
   bit          quiet;
   logic [7:0]  text_q[$];
   string       hex_chars    = "0123456789abcdefABCDEF";
   string       letter_chars = "abeEfnrtv\\";

   always #5 clock = ~clock;

   echo_escape_decoder_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   function automatic void clear_escape();
      esc_phase  = eed_pkg::PH_IDLE;
      esc_value  = '0;
      esc_digits = 0;
      esc_long   = 1'b0;
   endfunction

   function automatic void emit(logic [7:0] b);
      if (run_bytes.size() < eed_pkg::RUN_MAX) begin
         run_bytes.push_back(b);
      end
   endfunction

   // -1 for a byte that is not a hex digit
   function automatic int hex_of(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h57;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h37;
      return -1;
   endfunction

   function automatic void emit_utf8(logic [31:0] cp);
      int         nbytes;
      logic [7:0] lead;
      if (cp <= 32'h7F) begin
         emit(cp[7:0]);
         return;
      end
      if (cp > 32'h7FFF_FFFF) return;
      if (cp <= 32'h7FF) begin
         nbytes = 2;
         lead   = 8'hC0;
      end else if (cp <= 32'hFFFF) begin
         nbytes = 3;
         lead   = 8'hE0;
      end else if (cp <= 32'h1F_FFFF) begin
         nbytes = 4;
         lead   = 8'hF0;
      end else if (cp <= 32'h3FF_FFFF) begin
         nbytes = 5;
         lead   = 8'hF8;
      end else begin
         nbytes = 6;
         lead   = 8'hFC;
      end
      emit(lead | 8'(cp >> (6 * (nbytes - 1))));
      for (int i = nbytes - 2; i >= 0; i--) begin
         emit(8'h80 | {2'b00, 6'(cp >> (6 * i))});
      end
   endfunction

   function automatic void flush_escape();
      case (esc_phase)
         eed_pkg::PH_BSLASH: emit(eed_pkg::CH_BSLASH);
         eed_pkg::PH_OCT:    emit(esc_value[7:0]);
         eed_pkg::PH_HEX: begin
            if (esc_digits == 0) begin
               emit(eed_pkg::CH_BSLASH);
               emit("x");
            end else begin
               emit(esc_value[7:0]);
            end
         end
         eed_pkg::PH_UNI: begin
            if (esc_digits == 0) begin
               emit(eed_pkg::CH_BSLASH);
               emit(esc_long ? 8'("U") : 8'("u"));
            end else begin
               emit_utf8(esc_value);
            end
         end
         default: ;
      endcase
      clear_escape();
   endfunction

   function automatic void after_backslash(logic [7:0] b);
      clear_escape();
      case (b)
         "a":       emit(8'h07);
         "b":       emit(8'h08);
         "c":       stop_mark = 1'b1;
         "e", "E":  emit(eed_pkg::ESC_CODE);
         "f":       emit(8'h0C);
         "n":       emit(8'h0A);
         "r":       emit(8'h0D);
         "t":       emit(8'h09);
         "v":       emit(8'h0B);
         eed_pkg::CH_BSLASH: emit(eed_pkg::CH_BSLASH);
         "0": begin
            esc_phase  = eed_pkg::PH_OCT;
            esc_digits = 1;
         end
         "x":       esc_phase = eed_pkg::PH_HEX;
         "u":       esc_phase = eed_pkg::PH_UNI;
         "U": begin
            esc_phase = eed_pkg::PH_UNI;
            esc_long  = 1'b1;
         end
         default: begin
            emit(eed_pkg::CH_BSLASH);
            emit(b);
         end
      endcase
   endfunction

   function automatic void decode_byte(logic [7:0] b);
      int          h;
      int unsigned digit_limit;
      h = hex_of(b);
      case (esc_phase)
         eed_pkg::PH_OCT: begin
            if (b >= 8'h30 && b <= 8'h37 && esc_digits < 4) begin
               esc_value = (esc_value << 3) | {29'd0, b[2:0]};
               esc_digits++;
               if (esc_digits >= 4) begin
                  emit(esc_value[7:0]);
                  clear_escape();
               end
               return;
            end
            flush_escape();
         end
         eed_pkg::PH_HEX: begin
            if (h >= 0 && esc_digits < 2) begin
               esc_value = (esc_value << 4) | 32'(h);
               esc_digits++;
               if (esc_digits >= 2) begin
                  emit(esc_value[7:0]);
                  clear_escape();
               end
               return;
            end
            flush_escape();
         end
         eed_pkg::PH_UNI: begin
            digit_limit = esc_long ? 8 : 4;
            if (h >= 0 && esc_digits < digit_limit) begin
               esc_value = (esc_value << 4) | 32'(h);
               esc_digits++;
               if (esc_digits >= digit_limit) begin
                  emit_utf8(esc_value);
                  clear_escape();
               end
               return;
            end
            flush_escape();
         end
         eed_pkg::PH_BSLASH: begin
            after_backslash(b);
            return;
         end
         default: ;
      endcase
      if (b == eed_pkg::CH_BSLASH) esc_phase = eed_pkg::PH_BSLASH;
      else emit(b);
   endfunction

   function automatic void predict_transfer(logic [7:0] b, logic eos, logic ms);
      run_bytes.delete();
      if (ms) begin
         stop_mark = 1'b0;
         clear_escape();
      end
      if (!stop_mark) begin
         if (!decode_on) begin
            clear_escape();
            emit(b);
         end else begin
            decode_byte(b);
            if (eos && !stop_mark) flush_escape();
         end
      end
      if (run_bytes.size() == 0) begin
         decoded_q.push_back(result_type'{8'h00, 1'b0, stop_mark, 1'b1});
      end else begin
         foreach (run_bytes[i]) begin
            decoded_q.push_back(result_type'{run_bytes[i], 1'b1, stop_mark,
                                             i == run_bytes.size() - 1});
         end
      end
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %h, actual %h", name, want, got);
         error_count++;
      end
   endfunction

   // prediction on request transfers, checking on response transfers
   always @(posedge clock) begin
      result_type want;
      if (!reset) begin
         if (csr_we) decode_on = csr_wdata;
         if (req_tvalid && req_tready) predict_transfer(req_tdata, req_tlast, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_q.size() == 0) begin
               $error("out_byte: expected nothing, actual %h", rsp_tdata);
               error_count++;
            end else begin
               want = decoded_q.pop_front();
               check_field("out_byte", want.data, rsp_tdata);
               check_field("byte_valid", 8'(want.valid), 8'(rsp_tuser[0]));
               check_field("stopped", 8'(want.stopped), 8'(rsp_tuser[1]));
               check_field("last_of_run", 8'(want.last), 8'(rsp_tlast));
            end
         end
      end
   end

   // response side: random stalls, plus a long hold when requested
   initial begin
      forever begin
         @(posedge clock);
         if (hold_len != 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_len - 1) @(posedge clock);
            hold_len = 0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10) - 1) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_byte(logic [7:0] b, logic eos, logic ms);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eos;
      req_tuser  <= ms;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   task automatic send_text(string s, bit eos_last, bit ms_first);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i], eos_last && i == s.len() - 1, ms_first && i == 0);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_decode(bit on);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= on;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic add_hex_digits(int unsigned count);
      repeat (count) text_q.push_back(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
   endtask

   task automatic add_fragment();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         text_q.push_back(8'($urandom_range(32, 126)));
      end else if (pick < 25) begin
         text_q.push_back(8'($urandom));
      end else begin
         text_q.push_back(eed_pkg::CH_BSLASH);
         if (pick < 37) begin
            text_q.push_back(letter_chars[$urandom_range(0, letter_chars.len() - 1)]);
         end else if (pick < 47) begin
            text_q.push_back("0");
            repeat ($urandom_range(0, 3)) text_q.push_back(8'h30 + 8'($urandom_range(0, 7)));
         end else if (pick < 58) begin
            text_q.push_back("x");
            add_hex_digits($urandom_range(0, 2));
         end else if (pick < 70) begin
            text_q.push_back("u");
            add_hex_digits($urandom_range(0, 4));
         end else if (pick < 88) begin
            text_q.push_back("U");
            add_hex_digits($urandom_range(0, 8));
         end else if (pick < 97) begin
            text_q.push_back(8'($urandom));
         end else begin
            text_q.push_back("c");
         end
      end
   endtask

   // strings of escape fragments, mixed with raw noise transfers
   task automatic random_strings(int unsigned count, int unsigned noise_pct);
      int unsigned stop_at;
      bit          ms_first;
      stop_at = sent_count + count;
      while (sent_count < stop_at) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            send_byte(8'($urandom), 1'($urandom), 1'($urandom));
         end else begin
            text_q.delete();
            repeat ($urandom_range(1, 4)) add_fragment();
            ms_first = ($urandom_range(0, 2) == 0);
            foreach (text_q[i]) begin
               send_byte(text_q[i], i == text_q.size() - 1, ms_first && i == 0);
            end
         end
      end
   endtask

   task automatic test_raw_copy();
      set_decode(1'b0);
      send_byte(8'h00, 1'b1, 1'b1);
      send_byte(8'hFF, 1'b0, 1'b0);
   endtask

   task automatic test_escape_forms();
      set_decode(1'b1);
      send_text("\\e", 1'b1, 1'b0);
      send_text("\\x4g", 1'b1, 1'b0);
      send_text("\\u", 1'b1, 1'b0);
      send_text("\\q", 1'b0, 1'b0);
      send_text("\\", 1'b1, 1'b0);
      send_byte(8'h00, 1'b1, 1'b0);
   endtask

   task automatic test_message_start();
      send_text("\\x", 1'b0, 1'b0);
      send_byte("A", 1'b0, 1'b1);
   endtask

   task automatic test_raw_with_pending();
      send_text("\\x", 1'b0, 1'b0);
      set_decode(1'b0);
      send_byte("z", 1'b0, 1'b0);
   endtask

   task automatic test_stop_escape();
      set_decode(1'b1);
      send_text("\\c", 1'b0, 1'b0);
      set_decode(1'b0);
      send_byte("y", 1'b1, 1'b0);
      send_byte("w", 1'b0, 1'b1);
   endtask

   task automatic test_random_decode();
      set_decode(1'b1);
      random_strings(220, 15);
   endtask

   task automatic test_random_raw();
      set_decode(1'b0);
      random_strings(40, 30);
   endtask

   task automatic test_output_stall();
      set_decode(1'b1);
      hold_len = LONG_HOLD;
      random_strings(40, 10);
   endtask

   task automatic test_full_rate();
      quiet = 1'b1;
      random_strings(100, 10);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_raw_copy();
      test_escape_forms();
      test_message_start();
      test_raw_with_pending();
      test_stop_escape();
      test_random_decode();
      test_random_raw();
      test_output_stall();
      test_full_rate();
      drain();
      if (error_count == 0) begin
         $display("echo_escape_decoder_core: match");
      end else begin
         $display("echo_escape_decoder_core: mismatch");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("echo_escape_decoder_core: mismatch");
      $finish;
   end

endmodule
